// ----- hw/rtl/memf_pkg.sv -----
`default_nettype none

package memf_pkg;

    // field widths
    localparam int CH_W     = 3;
    localparam int ECHO_W   = 15;
    localparam int DIST_W   = 9;
    localparam int FILL_W   = 2;

    // block sizing
    localparam int NUM_CHANNELS = 6;
    localparam int HIST_DEPTH   = 6;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // echo time to cm: q = (echo * DIV_MUL) >> DIV_SHIFT equals echo / 57 for 15-bit echo
    localparam int US_PER_CM = 57;
    localparam int DIV_SHIFT = ECHO_W + 6;
    localparam int DIV_MUL_W = 16;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((1 << DIV_SHIFT) + US_PER_CM - 1) / US_PER_CM);
    localparam int PROD_W = ECHO_W + DIV_MUL_W;
    localparam int QUOT_W = DIST_W + 1;

    localparam logic [DIST_W-1:0] OOR_RESET = DIST_W'(200);

    // fill levels
    localparam logic [FILL_W-1:0] FILL_MEDIAN = FILL_W'(2);
    localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(3);

    typedef logic [CH_W-1:0]     chan_t;
    typedef logic [ECHO_W-1:0]   echo_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [FILL_W-1:0]   fill_t;
    typedef logic [CH_IDX_W-1:0] chan_idx_t;

    // per-channel window entry: the two newest samples and the fill level
    typedef struct packed {
        fill_t fill;
        dist_t older;
        dist_t newer;
    } win_entry_t;

    // write request into the window store
    typedef struct packed {
        logic       en;
        chan_idx_t  addr;
        win_entry_t data;
    } win_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/memf_if.sv -----
`default_nettype none

// echo sample request channel
interface memf_in_if;
    import memf_pkg::*;

    logic  valid;
    logic  ready;
    chan_t channel;
    echo_t echo_us;

    modport source (output valid, output channel, output echo_us, input ready);
    modport sink   (input valid, input channel, input echo_us, output ready);
endinterface

// filtered distance request channel
interface memf_out_if;
    import memf_pkg::*;

    logic  valid;
    logic  ready;
    chan_t channel_out;
    dist_t filtered_cm;
    dist_t ref_min_cm;
    dist_t ref_max_cm;

    modport source (output valid, output channel_out, output filtered_cm,
                    output ref_min_cm, output ref_max_cm, input ready);
    modport sink   (input valid, input channel_out, input filtered_cm,
                    input ref_min_cm, input ref_max_cm, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/memf_win_ram.sv -----
`default_nettype none

module memf_win_ram (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  memf_pkg::chan_idx_t  rd_addr,
    input  memf_pkg::win_wr_t    wr,
    output memf_pkg::win_entry_t rd_entry
);
    import memf_pkg::*;

    win_entry_t              mem [NUM_CHANNELS];
    win_entry_t              rd_q_reg;
    logic                    rd_vld_reg;
    logic [NUM_CHANNELS-1:0] vld_reg;
    logic                    byp_hit_reg;
    win_entry_t              byp_data_reg;

    // memory write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            byp_data_reg <= wr.data;
        end
    end

    // entry valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg  <= vld_reg[rd_addr];
                byp_hit_reg <= wr.en && (wr.addr == rd_addr);
            end
        end
    end

    // forward a write that lands on the same edge as the read
    assign rd_entry = byp_hit_reg ? byp_data_reg : (rd_vld_reg ? rd_q_reg : '0);

endmodule

`default_nettype wire

// ----- hw/rtl/memf_ref_hist.sv -----
`default_nettype none

module memf_ref_hist (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  memf_pkg::dist_t push_val,
    output memf_pkg::dist_t lo_next,
    output memf_pkg::dist_t hi_next
);
    import memf_pkg::*;

    dist_t hist_reg  [HIST_DEPTH];
    dist_t hist_next [HIST_DEPTH];

    // history after this push, oldest first
    always_comb
    begin
        for (int k = 0; k < HIST_DEPTH - 1; k++)
        begin
            hist_next[k] = hist_reg[k + 1];
        end
        hist_next[HIST_DEPTH - 1] = push_val;
    end

    // min and max over the shifted history
    always_comb
    begin
        lo_next = hist_next[0];
        hi_next = hist_next[0];
        for (int k = 1; k < HIST_DEPTH; k++)
        begin
            if (hist_next[k] < lo_next)
            begin
                lo_next = hist_next[k];
            end
            if (hist_next[k] > hi_next)
            begin
                hi_next = hist_next[k];
            end
        end
    end

    // shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (push)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= hist_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/multichannel_echo_median_filter_core.sv -----
// channel    | dir | payload                                            | handshake
// sample     | in  | channel, echo_us                                   | valid/ready
// result     | out | channel_out, filtered_cm, ref_min_cm, ref_max_cm   | valid/ready
// cfg        | in  | cfg_wr_data (out-of-range limit)                   | cfg_wr_en
//
// one request per cycle unless result stalls; results pass stage 1, then the output register
// stage 0 divides by 57 and reads the window, stage 1 forms median or raw value, writes back
// same-channel requests on adjacent cycles are served by forwarding in the window store
// reset clears the window valid bits, channel-0 value and history at once, no clearing pass
// a stalled result holds stage 1; sample.ready drops only when both stages are full
`default_nettype none

module multichannel_echo_median_filter_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  memf_pkg::dist_t cfg_wr_data,
    memf_in_if.sink         sample,
    memf_out_if.source      result
);
    import memf_pkg::*;

    function automatic dist_t med3(input dist_t a, input dist_t b, input dist_t c);
        dist_t m;
        if ((a <= b && b <= c) || (c <= b && b <= a))
        begin
            m = b;
        end
        else if ((a <= c && c <= b) || (b <= c && c <= a))
        begin
            m = c;
        end
        else
        begin
            m = a;
        end
        return m;
    endfunction

    dist_t              oor_reg;

    logic               accept;
    logic               in_ready;
    logic               ch_ok0;
    chan_idx_t          ch_idx0;
    logic [PROD_W-1:0]  prod0;
    logic [QUOT_W-1:0]  quot0;
    dist_t              dist0;

    logic               s1_vld_reg;
    logic               s1_ok_reg;
    chan_t              s1_ch_reg;
    chan_idx_t          s1_idx_reg;
    dist_t              s1_dist_reg;
    logic               s1_adv;

    win_entry_t         rd_entry;
    win_wr_t            wr;
    dist_t              res1;
    fill_t              fill1_next;
    dist_t              f0_reg;
    dist_t              f0_next;
    dist_t              lo_next;
    dist_t              hi_next;

    logic               out_vld_reg;
    chan_t              out_ch_reg;
    dist_t              out_filt_reg;
    dist_t              out_lo_reg;
    dist_t              out_hi_reg;

    // out-of-range limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oor_reg <= OOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            oor_reg <= cfg_wr_data;
        end
    end

    // handshake
    assign s1_adv       = s1_vld_reg && (!out_vld_reg || result.ready);
    assign in_ready     = !s1_vld_reg || s1_adv;
    assign sample.ready = in_ready;
    assign accept       = sample.valid && in_ready;

    // stage 0: divide by 57 through the reciprocal, range limit at full precision
    assign ch_ok0  = (32'(sample.channel) < NUM_CHANNELS);
    assign ch_idx0 = CH_IDX_W'(sample.channel);
    assign prod0   = PROD_W'(sample.echo_us) * PROD_W'(DIV_MUL);
    assign quot0   = prod0[DIV_SHIFT +: QUOT_W];
    assign dist0   = (quot0 >= QUOT_W'(oor_reg)) ? '0 : quot0[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_vld_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg   <= ch_ok0;
            s1_ch_reg   <= sample.channel;
            s1_idx_reg  <= ch_idx0;
            s1_dist_reg <= dist0;
        end
    end

    // per-channel window store
    memf_win_ram u_win_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept && ch_ok0),
        .rd_addr  (ch_idx0),
        .wr       (wr),
        .rd_entry (rd_entry)
    );

    // stage 1: raw pass-through while filling, median once two samples are held
    always_comb
    begin
        if (rd_entry.fill < FILL_MEDIAN)
        begin
            res1       = s1_dist_reg;
            fill1_next = rd_entry.fill + FILL_W'(1);
        end
        else
        begin
            res1       = med3(rd_entry.older, rd_entry.newer, s1_dist_reg);
            fill1_next = FILL_FULL;
        end
    end

    assign wr.en         = s1_adv && s1_ok_reg;
    assign wr.addr       = s1_idx_reg;
    assign wr.data.fill  = fill1_next;
    assign wr.data.older = rd_entry.newer;
    assign wr.data.newer = s1_dist_reg;

    // channel-0 filtered value
    assign f0_next = (s1_ok_reg && (s1_idx_reg == '0)) ? res1 : f0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_reg <= '0;
        end
        else if (s1_adv)
        begin
            f0_reg <= f0_next;
        end
    end

    // channel-0 history with min and max
    memf_ref_hist u_ref_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s1_adv),
        .push_val (f0_next),
        .lo_next  (lo_next),
        .hi_next  (hi_next)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_ch_reg   <= s1_ch_reg;
            out_filt_reg <= s1_ok_reg ? res1 : '0;
            out_lo_reg   <= lo_next;
            out_hi_reg   <= hi_next;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.channel_out = out_ch_reg;
    assign result.filtered_cm = out_filt_reg;
    assign result.ref_min_cm  = out_lo_reg;
    assign result.ref_max_cm  = out_hi_reg;

`ifndef SYNTHESIS
    // an accepted request always occupies stage 1 on the next cycle
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_vld_reg)
        else $error("accepted request missing from stage 1");

    // while filling, the raw distance is passed through
    a_fill_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_ok_reg && (rd_entry.fill < FILL_MEDIAN))
        |=> (out_filt_reg == $past(s1_dist_reg)))
        else $error("raw distance not passed while filling");

    // history bounds stay ordered
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_lo_reg <= out_hi_reg))
        else $error("history minimum above maximum");

    // an unknown channel leaves the channel-0 value alone
    a_bad_ch_keeps_f0: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_ok_reg) |=> (f0_reg == $past(f0_reg)))
        else $error("channel-0 value changed by unknown channel");
`endif

endmodule

`default_nettype wire
